// ----- rtl/string_to_integer_parser_core_macros.svh -----
// Assertion helpers for the parser core.
`ifndef STRING_TO_INTEGER_PARSER_CORE_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define S2I_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s2i assertion failed");

// next-cycle implication
`define S2I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s2i assertion failed");

`endif

// ----- rtl/s2i_pkg.sv -----
`default_nettype none

package s2i_pkg;

  localparam int MAX_STR_LEN = 4096;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 13;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 8;
  localparam int PH_W        = 3;
  localparam int PROD_W      = VAL_W + BASE_W;

  localparam logic [PH_W-1:0] PH_SPACE  = 3'd0;
  localparam logic [PH_W-1:0] PH_SIGNED = 3'd1;
  localparam logic [PH_W-1:0] PH_ZERO   = 3'd2;
  localparam logic [PH_W-1:0] PH_DIGITS = 3'd3;
  localparam logic [PH_W-1:0] PH_DONE   = 3'd4;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STR_LEN);

  localparam logic [CHAR_W-1:0] CH_NUM0   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NUM9   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UA_M10 = 8'h37;
  localparam logic [CHAR_W-1:0] CH_LA_M10 = 8'h57;
  localparam logic [CHAR_W-1:0] CH_LX     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX     = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LB     = 8'h62;
  localparam logic [CHAR_W-1:0] CH_UB     = 8'h42;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;

  typedef struct packed {
    logic [PH_W-1:0]   phase;
    logic [VAL_W-1:0]  acc;
    logic [BASE_W-1:0] base;
    logic              neg;
    logic [POS_W-1:0]  pos;
    logic              sent;
  } st_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        offset;
  } res_t;

  typedef struct packed {
    logic              vld;
    logic [BASE_W-1:0] val;
  } dig_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic dig_t digit_of(input logic [CHAR_W-1:0] c);
    dig_t d;
    d.vld = 1'b1;
    d.val = '0;
    if (c >= CH_NUM0 && c <= CH_NUM9) begin
      d.val = BASE_W'(c - CH_NUM0);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d.val = BASE_W'(c - CH_UA_M10);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d.val = BASE_W'(c - CH_LA_M10);
    end else begin
      d.vld = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    return (p < POS_MAX) ? p + POS_W'(1) : p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/s2i_char_if.sv -----
`default_nettype none

interface s2i_char_if;
  logic                          valid;
  logic                          ready;
  logic [s2i_pkg::CHAR_W-1:0]    char_code;
  logic                          last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/s2i_res_if.sv -----
`default_nettype none

interface s2i_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [s2i_pkg::VAL_W-1:0]  parsed_value;
  logic [s2i_pkg::POS_W-1:0]         end_offset;

  modport source (output valid, output parsed_value, output end_offset, input ready);
  modport sink   (input valid, input parsed_value, input end_offset, output ready);
endinterface

`default_nettype wire

// ----- rtl/s2i_step.sv -----
`default_nettype none

module s2i_step (
  input  s2i_pkg::st_t                  st,
  input  logic [s2i_pkg::BASE_W-1:0]    cfg_base,
  input  logic [s2i_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  output s2i_pkg::st_t                  st_nxt,
  output logic                          emit,
  output s2i_pkg::res_t                 res
);

  s2i_pkg::st_t                  s;
  s2i_pkg::dig_t                 dig;
  logic                          taken;
  logic                          stop;
  logic [s2i_pkg::PROD_W-1:0]    prod;
  logic [s2i_pkg::VAL_W-1:0]     mag;

  assign dig = s2i_pkg::digit_of(char_code);

  always_comb begin
    s     = st;
    taken = 1'b0;
    stop  = 1'b0;
    prod  = '0;

    if (s.phase == s2i_pkg::PH_SPACE) begin
      s.base = cfg_base;
      if (s2i_pkg::is_space(char_code)) begin
        s.pos = s2i_pkg::pos_inc(s.pos);
        taken = 1'b1;
      end else if (char_code == s2i_pkg::CH_MINUS || char_code == s2i_pkg::CH_PLUS) begin
        s.neg   = (char_code == s2i_pkg::CH_MINUS);
        s.pos   = s2i_pkg::pos_inc(s.pos);
        s.phase = s2i_pkg::PH_SIGNED;
        taken   = 1'b1;
      end else begin
        s.phase = s2i_pkg::PH_SIGNED;
      end
    end

    if (!taken && s.phase == s2i_pkg::PH_SIGNED) begin
      if ((s.base == s2i_pkg::BASE_AUTO || s.base == s2i_pkg::BASE_HEX ||
           s.base == s2i_pkg::BASE_BIN) && char_code == s2i_pkg::CH_NUM0) begin
        s.pos   = s2i_pkg::pos_inc(s.pos);
        s.phase = s2i_pkg::PH_ZERO;
        taken   = 1'b1;
      end else begin
        if (s.base == s2i_pkg::BASE_AUTO) begin
          s.base = s2i_pkg::BASE_DEC;
        end
        s.phase = s2i_pkg::PH_DIGITS;
      end
    end else if (!taken && s.phase == s2i_pkg::PH_ZERO) begin
      if ((char_code == s2i_pkg::CH_LX || char_code == s2i_pkg::CH_UX) &&
          (s.base == s2i_pkg::BASE_AUTO || s.base == s2i_pkg::BASE_HEX)) begin
        s.base  = s2i_pkg::BASE_HEX;
        s.pos   = s2i_pkg::pos_inc(s.pos);
        s.phase = s2i_pkg::PH_DIGITS;
        taken   = 1'b1;
      end else if ((char_code == s2i_pkg::CH_LB || char_code == s2i_pkg::CH_UB) &&
                   (s.base == s2i_pkg::BASE_AUTO || s.base == s2i_pkg::BASE_BIN)) begin
        s.base  = s2i_pkg::BASE_BIN;
        s.pos   = s2i_pkg::pos_inc(s.pos);
        s.phase = s2i_pkg::PH_DIGITS;
        taken   = 1'b1;
      end else begin
        if (s.base == s2i_pkg::BASE_AUTO) begin
          s.base = s2i_pkg::BASE_DEC;
        end
        s.phase = s2i_pkg::PH_DIGITS;
      end
    end

    if (!taken && s.phase == s2i_pkg::PH_DIGITS) begin
      if (!dig.vld || dig.val >= s.base) begin
        stop    = 1'b1;
        s.phase = s2i_pkg::PH_DONE;
        s.sent  = 1'b1;
      end else begin
        prod  = s.acc * s.base;
        s.acc = s2i_pkg::VAL_W'(prod) + s2i_pkg::VAL_W'(dig.val);
        s.pos = s2i_pkg::pos_inc(s.pos);
      end
    end

    mag        = s.neg ? (~s.acc + s2i_pkg::VAL_W'(1)) : s.acc;
    res.value  = $signed(mag);
    res.offset = s.pos;
    emit       = stop || (last_char && !s.sent);

    st_nxt = s;
    if (last_char) begin
      st_nxt.phase = s2i_pkg::PH_SPACE;
      st_nxt.acc   = '0;
      st_nxt.base  = cfg_base;
      st_nxt.neg   = 1'b0;
      st_nxt.pos   = '0;
      st_nxt.sent  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/s2i_out_buf.sv -----
`default_nettype none

module s2i_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  s2i_pkg::res_t     res,
  output logic              free,
  s2i_res_if.source         out_ch
);

  logic          vld_r;
  logic          vld_nxt;
  s2i_pkg::res_t res_r;

  assign free    = !vld_r || out_ch.ready;
  assign vld_nxt = load || (vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.parsed_value = res_r.value;
  assign out_ch.end_offset   = res_r.offset;

endmodule

`default_nettype wire

// ----- rtl/string_to_integer_parser_core.sv -----
// Beats are parsed from the input register into the state and result registers.
// Throughput: one character beat per cycle, held off only while a result beat stalls.
// Per-character work is one 32x6 multiply-add between the input and result registers.
// Reset (rst_n low, synchronous): parser back to white-space skip, base register to 10,
// input and result registers empty.
`default_nettype none

module string_to_integer_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [s2i_pkg::BASE_W-1:0]    cfg_wr_data,
  s2i_char_if.sink                      in_ch,
  s2i_res_if.source                     out_ch
);

  `include "string_to_integer_parser_core_macros.svh"

  logic                          in_vld_r;
  logic [s2i_pkg::CHAR_W-1:0]    in_char_r;
  logic                          in_last_r;
  logic [s2i_pkg::BASE_W-1:0]    base_r;
  s2i_pkg::st_t                  st_r;
  s2i_pkg::st_t                  st_nxt;
  s2i_pkg::res_t                 res;
  logic                          emit;
  logic                          out_free;
  logic                          consume;
  logic                          load;

  s2i_step u_step (
    .st        (st_r),
    .cfg_base  (base_r),
    .char_code (in_char_r),
    .last_char (in_last_r),
    .st_nxt    (st_nxt),
    .emit      (emit),
    .res       (res)
  );

  s2i_out_buf u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

  assign consume     = in_vld_r && (!emit || out_free);
  assign load        = consume && emit;
  assign in_ch.ready = !in_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_char_r <= in_ch.char_code;
      in_last_r <= in_ch.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= s2i_pkg::BASE_RESET;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= s2i_pkg::PH_SPACE;
      st_r.acc   <= '0;
      st_r.base  <= s2i_pkg::BASE_RESET;
      st_r.neg   <= 1'b0;
      st_r.pos   <= '0;
      st_r.sent  <= 1'b0;
    end else if (consume) begin
      st_r <= st_nxt;
    end
  end

  `S2I_ASSERT_NOW(a_sent_done, clk, rst_n, st_r.sent, st_r.phase == s2i_pkg::PH_DONE)
  `S2I_ASSERT_NOW(a_pos_sat, clk, rst_n, 1'b1, st_r.pos <= s2i_pkg::POS_MAX)
  `S2I_ASSERT_NEXT(a_last_clears, clk, rst_n, consume && in_last_r, st_r.phase == s2i_pkg::PH_SPACE && st_r.pos == '0 && !st_r.sent)
  `S2I_ASSERT_NOW(a_load_free, clk, rst_n, load, !out_ch.valid || out_ch.ready)

endmodule

`default_nettype wire

// ----- tb/tb_string_to_integer_parser_core.sv -----
`default_nettype none

module tb_string_to_integer_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import s2i_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [BASE_W-1:0] cfg_wr_data;

  s2i_char_if char_bus();
  s2i_res_if  res_bus();

  string_to_integer_parser_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (char_bus),
    .out_ch      (res_bus)
  );

  // parser state as seen from outside
  logic [PH_W-1:0]   ph;
  logic [VAL_W-1:0]  acc;
  logic [BASE_W-1:0] base_reg;
  logic [BASE_W-1:0] eff_base;
  logic              neg;
  logic [POS_W-1:0]  pos;
  logic              sent;

  res_t parse_results_q[$];

  int err_cnt;
  int beats_sent;
  int stall_left;
  bit gaps_on;
  bit stalls_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

  task automatic clear_parse();
    ph       = PH_SPACE;
    acc      = '0;
    eff_base = base_reg;
    neg      = 1'b0;
    pos      = '0;
    sent     = 1'b0;
  endtask

  task automatic step_pos();
    if (pos < POS_MAX) pos++;
  endtask

  task automatic emit_result();
    res_t r;
    r.value  = neg ? -acc : acc;
    r.offset = pos;
    parse_results_q.push_back(r);
    sent = 1'b1;
    ph   = PH_DONE;
  endtask

  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
    logic       taken;
    logic [6:0] dv;
    taken = 1'b0;
    if (ph == PH_SPACE) begin
      eff_base = base_reg;
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        step_pos();
        taken = 1'b1;
      end else if (c == CH_MINUS || c == CH_PLUS) begin
        neg = (c == CH_MINUS);
        step_pos();
        ph    = PH_SIGNED;
        taken = 1'b1;
      end else begin
        ph = PH_SIGNED;
      end
    end
    if (!taken && ph == PH_SIGNED) begin
      if ((eff_base == BASE_AUTO || eff_base == BASE_HEX || eff_base == BASE_BIN) &&
          c == CH_NUM0) begin
        step_pos();
        ph    = PH_ZERO;
        taken = 1'b1;
      end else begin
        if (eff_base == BASE_AUTO) eff_base = BASE_DEC;
        ph = PH_DIGITS;
      end
    end else if (!taken && ph == PH_ZERO) begin
      if ((c == CH_LX || c == CH_UX) && (eff_base == BASE_AUTO || eff_base == BASE_HEX)) begin
        eff_base = BASE_HEX;
        step_pos();
        ph    = PH_DIGITS;
        taken = 1'b1;
      end else if ((c == CH_LB || c == CH_UB) &&
                   (eff_base == BASE_AUTO || eff_base == BASE_BIN)) begin
        eff_base = BASE_BIN;
        step_pos();
        ph    = PH_DIGITS;
        taken = 1'b1;
      end else begin
        // the pending zero was a digit
        if (eff_base == BASE_AUTO) eff_base = BASE_DEC;
        ph = PH_DIGITS;
      end
    end
    if (!taken && ph == PH_DIGITS) begin
      if (c >= CH_NUM0 && c <= CH_NUM9) begin
        dv = 7'(c - CH_NUM0);
      end else if (c >= CH_UA && c <= CH_UZ) begin
        dv = 7'(c - CH_UA_M10);
      end else if (c >= CH_LA && c <= CH_LZ) begin
        dv = 7'(c - CH_LA_M10);
      end else begin
        dv = 7'h7f;
      end
      if (dv >= 7'(eff_base)) begin
        emit_result();
      end else begin
        acc = acc * VAL_W'(eff_base) + VAL_W'(dv);
        step_pos();
      end
    end
    if (last) begin
      if (!sent) emit_result();
      clear_parse();
    end
  endtask

  // result side: random ready stalls while stalls_on is set, compare every accepted beat
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_bus.ready = 1'b0;
      stall_left    = stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      res_bus.ready = 1'b0;
      stall_left    = $urandom_range(0, 4);
    end else begin
      res_bus.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t r;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (parse_results_q.size() == 0) begin
        $error("result beat with nothing pending: parsed_value %0d end_offset %0d",
               res_bus.parsed_value, res_bus.end_offset);
        err_cnt++;
      end else begin
        r = parse_results_q.pop_front();
        if (res_bus.parsed_value !== r.value) begin
          $error("parsed_value: expected %0d, actual %0d", r.value, res_bus.parsed_value);
          err_cnt++;
        end
        if (res_bus.end_offset !== r.offset) begin
          $error("end_offset: expected %0d, actual %0d", r.offset, res_bus.end_offset);
          err_cnt++;
        end
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      char_bus.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    char_bus.valid     = 1'b1;
    char_bus.char_code = c;
    char_bus.last_char = last;
    do @(posedge clk); while (!char_bus.ready);
    parse_char(c, last);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_idle();
    char_bus.valid = 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_base(input logic [BASE_W-1:0] b);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = b;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    base_reg  = b;
    if (ph == PH_SPACE) eff_base = b;
  endtask

  task automatic send_random_string();
    logic [CHAR_W-1:0] s[$];
    int gb;
    int lim;
    int n;
    int v;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2))
        s.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
      case ($urandom_range(0, 2))
        1: s.push_back(CH_PLUS);
        2: s.push_back(CH_MINUS);
        default: ;
      endcase
      gb = (base_reg == BASE_AUTO) ? 10 : int'(base_reg);
      if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && $urandom_range(0, 1)) begin
        s.push_back(CH_NUM0);
        s.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        gb = 16;
      end else if ((base_reg == BASE_AUTO || base_reg == BASE_BIN) && $urandom_range(0, 1)) begin
        s.push_back(CH_NUM0);
        s.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
        gb = 2;
      end
      lim = (gb > 36) ? 36 : gb;
      n   = (gb == 2) ? $urandom_range(0, 34) : $urandom_range(0, 12);
      repeat (n) begin
        v = $urandom_range(0, lim - 1);
        if (v < 10) begin
          s.push_back(8'(CH_NUM0 + v));
        end else begin
          s.push_back(8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + v - 10));
        end
      end
      // stop character and trailing junk, or end right on the last digit
      if (n == 0 || $urandom_range(0, 3) != 0) begin
        s.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic test_space_and_sign();
    send_text(" \011\012\013\014\015+7");
    send_text("-");
    send_text("- 5");
    send_text("\011  ");
    send_char("1", 1'b0);
    send_char(8'h00, 1'b0);
    send_char("5", 1'b0);
    send_char(8'hff, 1'b1);
    send_char(8'h80, 1'b1);
    send_text("-2147483648");
    send_text("-2147483649");
  endtask

  task automatic test_prefixes();
    set_base(BASE_AUTO);
    send_text("0x1F");
    send_text("0B101");
    send_text("0x");
    send_text("012");
    send_text("-0XZ");
    send_text("0b2");
    set_base(BASE_HEX);
    send_text("0xFfg");
    send_text("0b1");
    send_text("80000000");
    set_base(BASE_BIN);
    send_text("0b");
    send_text("0x1");
    send_text("-0B11");
  endtask

  task automatic test_bases();
    set_base(6'd1);
    send_text("001");
    set_base(6'd36);
    send_text("zZ");
    set_base(6'd63);
    send_text("Zz{");
    set_base(BASE_DEC);
  endtask

  task automatic test_random_strings(input int n);
    int stop_at;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      // base changes need an idle core, so none in the gap-free phase
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 7))
          0: set_base(BASE_AUTO);
          1: set_base(BASE_BIN);
          2: set_base(BASE_HEX);
          3: set_base(BASE_DEC);
          4: set_base(6'd63);
          5: set_base(6'd1);
          6: set_base(6'd36);
          default: set_base(6'($urandom_range(0, 63)));
        endcase
      end
      send_random_string();
    end
  endtask

  task automatic test_back_to_back(input int n);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_strings(n);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    char_bus.last_char = 1'b0;
    res_bus.ready      = 1'b0;
    err_cnt            = 0;
    beats_sent         = 0;
    stall_left         = 0;
    gaps_on            = 1'b1;
    stalls_on          = 1'b1;
    base_reg           = BASE_RESET;
    clear_parse();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_space_and_sign();
    test_prefixes();
    test_bases();
    test_random_strings(1500);
    test_back_to_back(500);

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
